// ===== design/bffd_pkg.sv =====
package bffd_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int LATTICE_POINTS    = 64;
    localparam int LATTICE_SIDE      = 4;
    localparam int AXES              = 3;
    localparam int COORD_W           = 32;
    localparam int CP_IDX_W          = $clog2(LATTICE_POINTS);
    localparam int GRID_IDX_W        = $clog2(LATTICE_SIDE);
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_DEFORM = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPAN_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPAN_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPAN_Z = 3'd5;

    typedef logic signed [COORD_W-1:0] coord_t;

endpackage

// ===== design/bffd_req_if.sv =====
interface bffd_req_if;

    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [bffd_pkg::CP_IDX_W-1:0]   cp_index;
    bffd_pkg::coord_t                coord_x;
    bffd_pkg::coord_t                coord_y;
    bffd_pkg::coord_t                coord_z;

    modport source (
        output valid,
        output req_type,
        output cp_index,
        output coord_x,
        output coord_y,
        output coord_z,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  cp_index,
        input  coord_x,
        input  coord_y,
        input  coord_z,
        output ready
    );

endinterface

// ===== design/bffd_res_if.sv =====
interface bffd_res_if;

    logic             valid;
    logic             ready;
    bffd_pkg::coord_t out_x;
    bffd_pkg::coord_t out_y;
    bffd_pkg::coord_t out_z;

    modport source (
        output valid,
        output out_x,
        output out_y,
        output out_z,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_x,
        input  out_y,
        input  out_z,
        output ready
    );

endinterface

// ===== design/bezier_free_form_deformation.sv =====
// Tricubic Bezier free-form deformation over a 4x4x4 control lattice.
// req channel: req_type 0 writes control point cp_index with (coord_x, coord_y,
// coord_z); req_type 1 deforms the point carried in the coordinates.
// res channel: one beat per deform beat with out_x, out_y, out_z; writes give none.
// cfg port: origin and reciprocal span per axis, written while the block is idle; the block does not enforce this.
// A write beat is taken while the block stays idle; the next beat may follow in the next cycle.
// A deform beat runs from acceptance to a valid result in order: the Bernstein
// weights (21 products through one shared 32x32 multiplier, issue and write-back
// each), then reading one control point a cycle from the lattice memory with a
// multiply-accumulate per axis, then draining that pipeline, and last loading the
// output register.
// req.ready is high only while no deform is in progress, so no new beat is taken
// until a deform has loaded its result; the weight sequence and the memory read loop set the spacing.
// The result waits in an output register; the block takes new beats while it
// waits, and a following deform holds in its last cycle until the register is free.
// Reset clears the control state and loads the reset values of the configuration and output registers;
// the lattice memory is not cleared, each entry must be written before use.
module bezier_free_form_deformation #(
    parameter int FRAC_BITS = bffd_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bffd_req_if.sink                        req,
    bffd_res_if.source                      res,
    input  logic                            cfg_we,
    input  logic [bffd_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [bffd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AXES         = bffd_pkg::AXES;
    localparam int LATTICE_SIDE = bffd_pkg::LATTICE_SIDE;
    localparam int COORD_W      = bffd_pkg::COORD_W;
    localparam int CP_IDX_W     = bffd_pkg::CP_IDX_W;
    localparam int GI_W         = bffd_pkg::GRID_IDX_W;
    localparam int W_W          = FRAC_BITS + 1;
    localparam int PROD_W       = COORD_W + W_W + 1;
    localparam int ACC_W        = PROD_W + CP_IDX_W;
    localparam int Q_W          = ACC_W - FRAC_BITS;
    localparam int CNT_W        = CP_IDX_W + 1;
    localparam int MUL_W        = 2 * COORD_W;
    localparam int PT_W         = AXES * COORD_W;

    localparam logic [W_W-1:0]     ONE            = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [COORD_W-1:0] INV_SPAN_RESET = COORD_W'(ONE);
    localparam logic [1:0]         LAST_AXIS      = 2'(AXES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WGT,
        ST_ACC,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_PARAM,
        OP_T2,
        OP_R2,
        OP_T3,
        OP_R3,
        OP_B1,
        OP_B2
    } wop_t;

    // configuration
    bffd_pkg::coord_t   origin_reg   [AXES];
    logic [COORD_W-1:0] inv_span_reg [AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                origin_reg[a]   <= '0;
                inv_span_reg[a] <= INV_SPAN_RESET;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                bffd_pkg::CFG_ORIGIN_X:   origin_reg[0]   <= $signed(cfg_wdata);
                bffd_pkg::CFG_ORIGIN_Y:   origin_reg[1]   <= $signed(cfg_wdata);
                bffd_pkg::CFG_ORIGIN_Z:   origin_reg[2]   <= $signed(cfg_wdata);
                bffd_pkg::CFG_INV_SPAN_X: inv_span_reg[0] <= cfg_wdata;
                bffd_pkg::CFG_INV_SPAN_Y: inv_span_reg[1] <= cfg_wdata;
                bffd_pkg::CFG_INV_SPAN_Z: inv_span_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // control
    state_t                state_reg;
    wop_t                  op_reg;
    logic                  phase_reg;
    logic [1:0]            axis_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [2:0]            v_reg;
    logic                  res_valid_reg;
    bffd_pkg::coord_t      out_reg [AXES];

    logic                  req_acc;
    logic                  res_take;
    logic                  wgt_last;
    logic                  issue;
    logic                  flushed;
    logic                  out_free;
    bffd_pkg::coord_t      sat_val [AXES];

    assign req.ready = (state_reg == ST_IDLE);
    assign req_acc   = req.valid & req.ready;
    assign res_take  = res_valid_reg & res.ready;
    assign out_free  = !res_valid_reg || res.ready;
    assign wgt_last  = (state_reg == ST_WGT) && phase_reg && (op_reg == OP_B2)
                       && (axis_reg == LAST_AXIS);
    assign issue     = (state_reg == ST_ACC) && !cnt_reg[CNT_W-1];
    assign flushed   = cnt_reg[CNT_W-1] && (v_reg == 3'b000);

    assign res.valid = res_valid_reg;
    assign res.out_x = out_reg[0];
    assign res.out_y = out_reg[1];
    assign res.out_z = out_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_PARAM;
            phase_reg     <= 1'b0;
            axis_reg      <= '0;
            cnt_reg       <= '0;
            v_reg         <= '0;
            res_valid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                out_reg[a] <= '0;
            end
        end
        else
        begin
            v_reg <= {v_reg[1:0], issue};
            if (res_take && (state_reg != ST_FIN))
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_acc && (req.req_type == bffd_pkg::REQ_DEFORM))
                    begin
                        state_reg <= ST_WGT;
                        op_reg    <= OP_PARAM;
                        phase_reg <= 1'b0;
                        axis_reg  <= '0;
                    end
                end
                ST_WGT:
                begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg)
                    begin
                        if (op_reg == OP_B2)
                        begin
                            op_reg <= OP_PARAM;
                            if (axis_reg == LAST_AXIS)
                            begin
                                state_reg <= ST_ACC;
                                cnt_reg   <= '0;
                            end
                            else
                            begin
                                axis_reg <= axis_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            op_reg <= wop_t'(op_reg + 3'd1);
                        end
                    end
                end
                ST_ACC:
                begin
                    if (issue)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    else if (flushed)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        for (int a = 0; a < AXES; a++)
                        begin
                            out_reg[a] <= sat_val[a];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // point under deformation
    bffd_pkg::coord_t pt_reg [AXES];

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            pt_reg[0] <= req.coord_x;
            pt_reg[1] <= req.coord_y;
            pt_reg[2] <= req.coord_z;
        end
    end

    // bernstein weights, one shared multiplier
    logic [MUL_W-1:0]   mul_p_reg;
    logic [W_W-1:0]     t_reg;
    logic [W_W-1:0]     r_reg;
    logic [W_W-1:0]     t2_reg;
    logic [W_W-1:0]     r2_reg;
    logic [W_W-1:0]     wgt_reg [AXES][LATTICE_SIDE];

    logic signed [COORD_W:0] d_diff;
    logic [COORD_W-1:0]      d_pos;
    logic [COORD_W-1:0]      mul_a;
    logic [COORD_W-1:0]      mul_b;
    logic [W_W-1:0]          p_frac;
    logic [W_W-1:0]          t_cap;
    logic [MUL_W+1:0]        p3;
    logic [W_W-1:0]          p3_frac;

    always_comb
    begin
        d_diff  = {pt_reg[axis_reg][COORD_W-1], pt_reg[axis_reg]}
                  - {origin_reg[axis_reg][COORD_W-1], origin_reg[axis_reg]};
        d_pos   = d_diff[COORD_W] ? '0 : d_diff[COORD_W-1:0];
        p_frac  = mul_p_reg[FRAC_BITS +: W_W];
        t_cap   = ((mul_p_reg >> FRAC_BITS) > MUL_W'(ONE)) ? ONE : p_frac;
        p3      = {2'b00, mul_p_reg} + {1'b0, mul_p_reg, 1'b0};
        p3_frac = p3[FRAC_BITS +: W_W];
        case (op_reg)
            OP_PARAM:
            begin
                mul_a = d_pos;
                mul_b = inv_span_reg[axis_reg];
            end
            OP_T2:
            begin
                mul_a = COORD_W'(t_reg);
                mul_b = COORD_W'(t_reg);
            end
            OP_R2:
            begin
                mul_a = COORD_W'(r_reg);
                mul_b = COORD_W'(r_reg);
            end
            OP_T3:
            begin
                mul_a = COORD_W'(t2_reg);
                mul_b = COORD_W'(t_reg);
            end
            OP_R3:
            begin
                mul_a = COORD_W'(r2_reg);
                mul_b = COORD_W'(r_reg);
            end
            OP_B1:
            begin
                mul_a = COORD_W'(r2_reg);
                mul_b = COORD_W'(t_reg);
            end
            OP_B2:
            begin
                mul_a = COORD_W'(t2_reg);
                mul_b = COORD_W'(r_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_WGT) && !phase_reg)
        begin
            mul_p_reg <= mul_a * mul_b;
        end
        if ((state_reg == ST_WGT) && phase_reg)
        begin
            case (op_reg)
                OP_PARAM:
                begin
                    t_reg <= t_cap;
                    r_reg <= ONE - t_cap;
                end
                OP_T2:   t2_reg <= p_frac;
                OP_R2:   r2_reg <= p_frac;
                OP_T3:   wgt_reg[axis_reg][3] <= p_frac;
                OP_R3:   wgt_reg[axis_reg][0] <= p_frac;
                OP_B1:   wgt_reg[axis_reg][1] <= p3_frac;
                OP_B2:   wgt_reg[axis_reg][2] <= p3_frac;
                default: ;
            endcase
        end
    end

    // lattice memory and accumulate pipeline
    logic [PT_W-1:0]          cp_mem [bffd_pkg::LATTICE_POINTS];
    logic [PT_W-1:0]          cp_rd_reg;
    logic [PT_W-1:0]          cp2_reg;
    logic [2*W_W-1:0]         wij_p_reg;
    logic [2*W_W-1:0]         wk_p_reg;
    logic [GI_W-1:0]          k1_reg;
    logic signed [PROD_W-1:0] prod_reg [AXES];
    logic signed [ACC_W-1:0]  acc_reg  [AXES];

    logic [CP_IDX_W-1:0]      rd_addr;
    logic [W_W-1:0]           w_cur;

    assign rd_addr = cnt_reg[CP_IDX_W-1:0];
    assign w_cur   = wk_p_reg[FRAC_BITS +: W_W];

    always_ff @(posedge clk)
    begin
        if (req_acc && (req.req_type == bffd_pkg::REQ_WRITE))
        begin
            cp_mem[req.cp_index] <= {req.coord_z, req.coord_y, req.coord_x};
        end
        cp_rd_reg <= cp_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        wij_p_reg <= wgt_reg[0][rd_addr[2*GI_W +: GI_W]] * wgt_reg[1][rd_addr[GI_W +: GI_W]];
        k1_reg    <= rd_addr[GI_W-1:0];
        cp2_reg   <= cp_rd_reg;
        wk_p_reg  <= wij_p_reg[FRAC_BITS +: W_W] * wgt_reg[2][k1_reg];
        for (int a = 0; a < AXES; a++)
        begin
            prod_reg[a] <= $signed(cp2_reg[a*COORD_W +: COORD_W]) * $signed({1'b0, w_cur});
            if (wgt_last)
            begin
                acc_reg[a] <= '0;
            end
            else if (v_reg[2])
            begin
                acc_reg[a] <= acc_reg[a] + ACC_W'(prod_reg[a]);
            end
        end
    end

    // floor shift and saturation
    logic signed [Q_W-1:0] q_val [AXES];

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            q_val[a] = acc_reg[a][ACC_W-1:FRAC_BITS];
            if ((&q_val[a][Q_W-1:COORD_W-1]) || !(|q_val[a][Q_W-1:COORD_W-1]))
            begin
                sat_val[a] = q_val[a][COORD_W-1:0];
            end
            else if (q_val[a][Q_W-1])
            begin
                sat_val[a] = {1'b1, {(COORD_W-1){1'b0}}};
            end
            else
            begin
                sat_val[a] = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    end

endmodule
